// ===== hdl/bmmd_pkg.sv =====
// banked memory map decoder: shared types, codes and store sizes
// no dependencies; used by every other file of the block

package bmmd_pkg;

  localparam int VRAM_BYTES     = 16384;
  localparam int WRAM_BYTES     = 32768;
  localparam int HRAM_BYTES     = 128;
  localparam int BOOT_ROM_BYTES = 2048;

  localparam int VRAM_AW = $clog2(VRAM_BYTES);
  localparam int WRAM_AW = $clog2(WRAM_BYTES);
  localparam int HRAM_AW = $clog2(HRAM_BYTES);
  localparam int BOOT_AW = $clog2(BOOT_ROM_BYTES);

  localparam int CLR_DEPTH_VW = (VRAM_BYTES > WRAM_BYTES) ? VRAM_BYTES : WRAM_BYTES;
  localparam int CLR_DEPTH    = (CLR_DEPTH_VW > HRAM_BYTES) ? CLR_DEPTH_VW : HRAM_BYTES;
  localparam int CLR_W        = $clog2(CLR_DEPTH);

  localparam int IDX_W = 17;

  localparam int OP_W    = 2;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int ROUTE_W = 2;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 8;
  localparam int WBANK_W = 3;

  localparam logic [OP_W-1:0] OP_CPU_RD    = 2'd0;
  localparam logic [OP_W-1:0] OP_CPU_WR    = 2'd1;
  localparam logic [OP_W-1:0] OP_PPU_RD    = 2'd2;
  localparam logic [OP_W-1:0] OP_BOOT_LOAD = 2'd3;

  localparam logic [ROUTE_W-1:0] ROUTE_INTERNAL = 2'd0;
  localparam logic [ROUTE_W-1:0] ROUTE_OAM      = 2'd1;
  localparam logic [ROUTE_W-1:0] ROUTE_IO       = 2'd2;
  localparam logic [ROUTE_W-1:0] ROUTE_CART     = 2'd3;

  localparam logic [CFG_IW-1:0] CFG_VRAM_BANK  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_WRAM_BANK  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_BOOT_EN    = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_BOOT_LARGE = 2'd3;

  localparam logic [ADDR_W-1:0] ADDR_VRAM_LO  = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_VRAM_HI  = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_WRAM_LO  = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_WRAM_BNK = 16'hD000;
  localparam logic [ADDR_W-1:0] ADDR_ECHO_LO  = 16'hE000;
  localparam logic [ADDR_W-1:0] ADDR_OAM_LO   = 16'hFE00;
  localparam logic [ADDR_W-1:0] ADDR_IO_LO    = 16'hFF00;
  localparam logic [ADDR_W-1:0] ADDR_HRAM_LO  = 16'hFF80;
  localparam logic [ADDR_W-1:0] ADDR_IE       = 16'hFFFF;
  localparam logic [ADDR_W-1:0] ADDR_PPU_HI   = 16'hC000;
  localparam logic [ADDR_W-1:0] ECHO_OFFSET   = 16'h2000;
  localparam logic [ADDR_W-1:0] MASK_8K       = 16'h1FFF;
  localparam logic [ADDR_W-1:0] MASK_16K      = 16'h3FFF;
  localparam logic [ADDR_W-1:0] MASK_4K       = 16'h0FFF;
  localparam logic [ADDR_W-1:0] BOOT_WIN0_HI  = 16'h0100;
  localparam logic [ADDR_W-1:0] BOOT_WIN1_LO  = 16'h0200;
  localparam logic [ADDR_W-1:0] BOOT_WIN1_HI  = 16'h0900;
  localparam logic [ADDR_W-1:0] BOOT_WIN1_OFS = 16'h0100;

  localparam logic [DATA_W-1:0] BAD_READ_DATA = 8'hFF;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data_value;
    logic              has_side_effect;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [ROUTE_W-1:0] route;
    logic [ADDR_W-1:0]  forward_address;
    logic [DATA_W-1:0]  forward_data;
    logic               forward_is_write;
    logic               forward_side_effect;
    logic               bad_access;
  } result_t;

  typedef struct packed {
    logic accept;
    logic load_out;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

// ===== hdl/bmmd_in_if.sv =====
// bus access channel: valid/ready handshake with one access item
// depends on bmmd_pkg for field widths

interface bmmd_in_if;
  logic                            valid;
  logic                            ready;
  logic [bmmd_pkg::OP_W-1:0]       operation;
  logic [bmmd_pkg::ADDR_W-1:0]     address;
  logic [bmmd_pkg::DATA_W-1:0]     data_value;
  logic                            has_side_effect;

  modport source (output valid, operation, address, data_value, has_side_effect,
                  input ready);
  modport sink (input valid, operation, address, data_value, has_side_effect,
                output ready);
endinterface

// ===== hdl/bmmd_out_if.sv =====
// decode result channel: valid/ready handshake with one result item
// depends on bmmd_pkg for field widths

interface bmmd_out_if;
  logic                            valid;
  logic                            ready;
  logic [bmmd_pkg::DATA_W-1:0]     read_data;
  logic [bmmd_pkg::ROUTE_W-1:0]    route;
  logic [bmmd_pkg::ADDR_W-1:0]     forward_address;
  logic [bmmd_pkg::DATA_W-1:0]     forward_data;
  logic                            forward_is_write;
  logic                            forward_side_effect;
  logic                            bad_access;

  modport source (output valid, read_data, route, forward_address, forward_data,
                  forward_is_write, forward_side_effect, bad_access,
                  input ready);
  modport sink (input valid, read_data, route, forward_address, forward_data,
                forward_is_write, forward_side_effect, bad_access,
                output ready);
endinterface

// ===== hdl/bmmd_cfg_if.sv =====
// configuration write channel: valid/ready with register index and data
// depends on bmmd_pkg for field widths

interface bmmd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bmmd_pkg::CFG_IW-1:0] reg_index;
  logic [bmmd_pkg::CFG_DW-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ===== hdl/bmmd_ctrl.sv =====
// controller: store clearing after reset, item accept and result hand-off
// depends on bmmd_pkg for command and status types

module bmmd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  bmmd_pkg::sts_t sts,
  output bmmd_pkg::cmd_t cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_DONE) && out_ready);
  assign out_valid = (state_r == S_DONE);
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd.accept   = accept;
    cmd.load_out = (state_r == S_READ);
    cmd.clear    = (state_r == S_CLEAR);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = accept ? S_READ : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/bmmd_dp.sv =====
// datapath: config registers, address decode, internal stores, result register
// depends on bmmd_pkg for sizes, codes and types

module bmmd_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bmmd_pkg::cmd_t              cmd,
  output bmmd_pkg::sts_t              sts,
  input  bmmd_pkg::item_t             item,
  input  logic                        cfg_we,
  input  logic [bmmd_pkg::CFG_IW-1:0] cfg_index,
  input  logic [bmmd_pkg::CFG_DW-1:0] cfg_data,
  output bmmd_pkg::result_t           res
);

  localparam logic [2:0] SRC_NONE = 3'd0;
  localparam logic [2:0] SRC_VRAM = 3'd1;
  localparam logic [2:0] SRC_WRAM = 3'd2;
  localparam logic [2:0] SRC_HRAM = 3'd3;
  localparam logic [2:0] SRC_BOOT = 3'd4;
  localparam logic [2:0] SRC_BAD  = 3'd5;

  localparam int AW = bmmd_pkg::ADDR_W;
  localparam int DW = bmmd_pkg::DATA_W;
  localparam int IW = bmmd_pkg::IDX_W;

  // config registers
  logic                         vram_bank_r;
  logic [bmmd_pkg::WBANK_W-1:0] wram_bank_r;
  logic                         boot_en_r;
  logic                         boot_large_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vram_bank_r  <= 1'b0;
      wram_bank_r  <= bmmd_pkg::WBANK_W'(1);
      boot_en_r    <= 1'b1;
      boot_large_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bmmd_pkg::CFG_VRAM_BANK:  vram_bank_r  <= cfg_data[0];
        bmmd_pkg::CFG_WRAM_BANK:  wram_bank_r  <= cfg_data[bmmd_pkg::WBANK_W-1:0];
        bmmd_pkg::CFG_BOOT_EN:    boot_en_r    <= cfg_data[0];
        bmmd_pkg::CFG_BOOT_LARGE: boot_large_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clearing pass counter
  logic [bmmd_pkg::CLR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clear_last = (clr_cnt_r == bmmd_pkg::CLR_W'(bmmd_pkg::CLR_DEPTH - 1));

  logic clr_in_vram, clr_in_wram, clr_in_hram;
  assign clr_in_vram = ({1'b0, clr_cnt_r} < (bmmd_pkg::CLR_W+1)'(bmmd_pkg::VRAM_BYTES));
  assign clr_in_wram = ({1'b0, clr_cnt_r} < (bmmd_pkg::CLR_W+1)'(bmmd_pkg::WRAM_BYTES));
  assign clr_in_hram = ({1'b0, clr_cnt_r} < (bmmd_pkg::CLR_W+1)'(bmmd_pkg::HRAM_BYTES));

  // address decode
  logic          is_rd, is_wr, is_ppu, is_load, is_cpu;
  logic [AW-1:0] a, m;
  logic          boot_lo, boot_hi, boot_hit;
  logic          vram_hit, wram_hit, hram_hit, ppu_ok, fwd;
  logic [bmmd_pkg::ROUTE_W-1:0] route;
  logic [IW-1:0] vsum, wsum, bsum;
  logic [2:0]    src;
  logic [AW-1:0] faddr;

  always_comb begin
    a       = item.address;
    is_rd   = (item.operation == bmmd_pkg::OP_CPU_RD);
    is_wr   = (item.operation == bmmd_pkg::OP_CPU_WR);
    is_ppu  = (item.operation == bmmd_pkg::OP_PPU_RD);
    is_load = (item.operation == bmmd_pkg::OP_BOOT_LOAD);
    is_cpu  = is_rd || is_wr;

    m = a;
    if (is_cpu && (a >= bmmd_pkg::ADDR_ECHO_LO) && (a < bmmd_pkg::ADDR_OAM_LO)) begin
      m = a - bmmd_pkg::ECHO_OFFSET;
    end

    boot_lo  = (m < bmmd_pkg::BOOT_WIN0_HI);
    boot_hi  = boot_large_r && (m >= bmmd_pkg::BOOT_WIN1_LO) && (m < bmmd_pkg::BOOT_WIN1_HI);
    boot_hit = is_rd && boot_en_r && (boot_lo || boot_hi);

    vram_hit = is_cpu && !boot_hit && (m >= bmmd_pkg::ADDR_VRAM_LO)
               && (m < bmmd_pkg::ADDR_VRAM_HI);
    wram_hit = is_cpu && !boot_hit && (m >= bmmd_pkg::ADDR_WRAM_LO)
               && (m < bmmd_pkg::ADDR_ECHO_LO);
    hram_hit = is_cpu && !boot_hit && (m >= bmmd_pkg::ADDR_HRAM_LO)
               && (m != bmmd_pkg::ADDR_IE);
    ppu_ok   = is_ppu && (a >= bmmd_pkg::ADDR_VRAM_LO) && (a < bmmd_pkg::ADDR_PPU_HI);
    fwd      = is_cpu && !boot_hit && !vram_hit && !wram_hit && !hram_hit;

    if (!fwd) begin
      route = bmmd_pkg::ROUTE_INTERNAL;
    end else if ((m >= bmmd_pkg::ADDR_OAM_LO) && (m < bmmd_pkg::ADDR_IO_LO)) begin
      route = bmmd_pkg::ROUTE_OAM;
    end else if ((m >= bmmd_pkg::ADDR_IO_LO) && (m < bmmd_pkg::ADDR_HRAM_LO)) begin
      route = bmmd_pkg::ROUTE_IO;
    end else if (m == bmmd_pkg::ADDR_IE) begin
      route = bmmd_pkg::ROUTE_IO;
    end else begin
      route = bmmd_pkg::ROUTE_CART;
    end

    // store sizes are powers of two, so the low index bits give the wrap
    if (is_ppu) begin
      vsum = IW'((a - bmmd_pkg::ADDR_VRAM_LO) & bmmd_pkg::MASK_16K);
    end else begin
      vsum = IW'(m & bmmd_pkg::MASK_8K) + (vram_bank_r ? IW'(bmmd_pkg::ECHO_OFFSET) : '0);
    end
    wsum = IW'(m & bmmd_pkg::MASK_4K)
           + ((m >= bmmd_pkg::ADDR_WRAM_BNK) ? IW'({wram_bank_r, 12'h000}) : '0);
    bsum = boot_lo ? IW'(m) : IW'(m - bmmd_pkg::BOOT_WIN1_OFS);

    if (boot_hit) begin
      src = SRC_BOOT;
    end else if ((vram_hit && is_rd) || ppu_ok) begin
      src = SRC_VRAM;
    end else if (wram_hit && is_rd) begin
      src = SRC_WRAM;
    end else if (hram_hit && is_rd) begin
      src = SRC_HRAM;
    end else if (is_ppu) begin
      src = SRC_BAD;
    end else begin
      src = SRC_NONE;
    end

    if (is_load) begin
      faddr = '0;
    end else if (is_ppu) begin
      faddr = a;
    end else begin
      faddr = m;
    end
  end

  // video ram
  logic [DW-1:0]                video_ram [bmmd_pkg::VRAM_BYTES];
  logic                         v_we;
  logic [bmmd_pkg::VRAM_AW-1:0] v_addr;
  logic [DW-1:0]                v_wd, vram_q_r;

  assign v_we   = cmd.clear ? clr_in_vram : (cmd.accept && is_wr && vram_hit);
  assign v_addr = cmd.clear ? clr_cnt_r[bmmd_pkg::VRAM_AW-1:0] : vsum[bmmd_pkg::VRAM_AW-1:0];
  assign v_wd   = cmd.clear ? '0 : item.data_value;

  always_ff @(posedge clk) begin
    if (v_we) begin
      video_ram[v_addr] <= v_wd;
    end
    if (cmd.accept) begin
      vram_q_r <= video_ram[v_addr];
    end
  end

  // work ram
  logic [DW-1:0]                work_ram [bmmd_pkg::WRAM_BYTES];
  logic                         w_we;
  logic [bmmd_pkg::WRAM_AW-1:0] w_addr;
  logic [DW-1:0]                w_wd, wram_q_r;

  assign w_we   = cmd.clear ? clr_in_wram : (cmd.accept && is_wr && wram_hit);
  assign w_addr = cmd.clear ? clr_cnt_r[bmmd_pkg::WRAM_AW-1:0] : wsum[bmmd_pkg::WRAM_AW-1:0];
  assign w_wd   = cmd.clear ? '0 : item.data_value;

  always_ff @(posedge clk) begin
    if (w_we) begin
      work_ram[w_addr] <= w_wd;
    end
    if (cmd.accept) begin
      wram_q_r <= work_ram[w_addr];
    end
  end

  // high ram
  logic [DW-1:0]                high_ram [bmmd_pkg::HRAM_BYTES];
  logic                         h_we;
  logic [bmmd_pkg::HRAM_AW-1:0] h_addr;
  logic [DW-1:0]                h_wd, hram_q_r;

  assign h_we   = cmd.clear ? clr_in_hram : (cmd.accept && is_wr && hram_hit);
  assign h_addr = cmd.clear ? clr_cnt_r[bmmd_pkg::HRAM_AW-1:0] : m[bmmd_pkg::HRAM_AW-1:0];
  assign h_wd   = cmd.clear ? '0 : item.data_value;

  always_ff @(posedge clk) begin
    if (h_we) begin
      high_ram[h_addr] <= h_wd;
    end
    if (cmd.accept) begin
      hram_q_r <= high_ram[h_addr];
    end
  end

  // boot rom store, loaded by items, never cleared
  logic [DW-1:0]                boot_rom_store [bmmd_pkg::BOOT_ROM_BYTES];
  logic                         b_we;
  logic [bmmd_pkg::BOOT_AW-1:0] b_addr;
  logic [DW-1:0]                boot_q_r;

  assign b_we   = cmd.accept && is_load
                  && ({1'b0, a} < (AW+1)'(bmmd_pkg::BOOT_ROM_BYTES));
  assign b_addr = is_load ? a[bmmd_pkg::BOOT_AW-1:0] : bsum[bmmd_pkg::BOOT_AW-1:0];

  always_ff @(posedge clk) begin
    if (b_we) begin
      boot_rom_store[b_addr] <= item.data_value;
    end
    if (cmd.accept) begin
      boot_q_r <= boot_rom_store[b_addr];
    end
  end

  // decode register, then result register
  logic [2:0]                   src_r;
  logic [bmmd_pkg::ROUTE_W-1:0] route_r;
  logic [AW-1:0]                faddr_r;
  logic [DW-1:0]                fdata_r;
  logic                         fwr_r, fse_r;
  bmmd_pkg::result_t            res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      src_r   <= src;
      route_r <= route;
      faddr_r <= faddr;
      fdata_r <= fwd ? item.data_value : '0;
      fwr_r   <= fwd && is_wr;
      fse_r   <= is_rd && (route == bmmd_pkg::ROUTE_CART) && item.has_side_effect;
    end
  end

  always_comb begin
    res_nxt.route               = route_r;
    res_nxt.forward_address     = faddr_r;
    res_nxt.forward_data        = fdata_r;
    res_nxt.forward_is_write    = fwr_r;
    res_nxt.forward_side_effect = fse_r;
    res_nxt.bad_access          = (src_r == SRC_BAD);
    case (src_r)
      SRC_VRAM: res_nxt.read_data = vram_q_r;
      SRC_WRAM: res_nxt.read_data = wram_q_r;
      SRC_HRAM: res_nxt.read_data = hram_q_r;
      SRC_BOOT: res_nxt.read_data = boot_q_r;
      SRC_BAD:  res_nxt.read_data = bmmd_pkg::BAD_READ_DATA;
      default:  res_nxt.read_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== hdl/banked_memory_map_decoder_top.sv =====
// top level of the banked memory map decoder: channel wiring
// depends on bmmd_pkg, the three channel interfaces, bmmd_ctrl and bmmd_dp
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   operation, address, data_value, has_side_effect
//   out_ch   out  valid/ready   read_data, route, forward_address, forward_data,
//                               forward_is_write, forward_side_effect, bad_access
//   cfg_ch   in   valid/ready   reg_index, wr_data (ready always high)
//
// for each item the accept edge does the store read or write and fills the
// decode registers; the result register is loaded from them in state S_READ
// a new item is taken in the same cycle the waiting result is taken
// after reset the stores are cleared, one entry per cycle up to CLR_DEPTH, the
// largest store depth, with in_ready low; config writes are taken throughout

module banked_memory_map_decoder_top (
  input logic       clk,
  input logic       rst_n,
  bmmd_in_if.sink   in_ch,
  bmmd_out_if.source out_ch,
  bmmd_cfg_if.sink  cfg_ch
);

  bmmd_pkg::cmd_t    cmd;
  bmmd_pkg::sts_t    sts;
  bmmd_pkg::item_t   item;
  bmmd_pkg::result_t res;

  assign item.operation       = in_ch.operation;
  assign item.address         = in_ch.address;
  assign item.data_value      = in_ch.data_value;
  assign item.has_side_effect = in_ch.has_side_effect;

  assign cfg_ch.ready = 1'b1;

  bmmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmmd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .item      (item),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.reg_index),
    .cfg_data  (cfg_ch.wr_data),
    .res       (res)
  );

  assign out_ch.read_data           = res.read_data;
  assign out_ch.route               = res.route;
  assign out_ch.forward_address     = res.forward_address;
  assign out_ch.forward_data        = res.forward_data;
  assign out_ch.forward_is_write    = res.forward_is_write;
  assign out_ch.forward_side_effect = res.forward_side_effect;
  assign out_ch.bad_access          = res.bad_access;

endmodule
